FILE: sv/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg: shared definitions for the fixed-point calculator
// Widths, command and status codes, and the job handed from front to back.
// ----------------------------------------------------------------------------
package scr_pkg;

   localparam int FIELD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int SAT_BITS  = (WORD_BITS < FIELD_W) ? WORD_BITS : FIELD_W;

   localparam int PROD_W = 2 * FIELD_W;
   localparam int RAD_W  = PROD_W + 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int DEN_W  = FIELD_W + 1;
   localparam int NUM_A  = ROOT_W + FRAC_BITS;
   localparam int NUM_B  = PROD_W - FRAC_BITS;
   localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;

   localparam int CMD_W = 3;
   localparam int ST_W  = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [NUM_W-1:0] SAT_LIM = NUM_W'(1) << (SAT_BITS - 1);

   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIN  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_QUAD = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NRM3 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_MINK = 3'd7;

   localparam logic [ST_W-1:0] ST_OK   = 3'd0;
   localparam logic [ST_W-1:0] ST_REAL = 3'd1;
   localparam logic [ST_W-1:0] ST_CPLX = 3'd2;
   localparam logic [ST_W-1:0] ST_DIVZ = 3'd3;
   localparam logic [ST_W-1:0] ST_SAT  = 3'd4;

   // one classified item: radicand, main dividend/divisor and routing flags
   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             root_main;
      logic             root_offs;
      logic [ST_W-1:0]  code;
   } job_type;

endpackage

FILE: sv/scr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_front: operand intake and classification
// Take magnitudes and signs, form the products, then build one job per beat.
// ----------------------------------------------------------------------------
module scr_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [scr_pkg::CMD_W-1:0]               in_cmd,
   input  logic [scr_pkg::FIELD_W-1:0]             in_a,
   input  logic [scr_pkg::FIELD_W-1:0]             in_b,
   input  logic [scr_pkg::FIELD_W-1:0]             in_c,
   input  logic [scr_pkg::FIELD_W-1:0]             in_d,
   output logic                                    job_valid,
   input  logic                                    job_full,
   output scr_pkg::job_type                        job
);

   localparam int FW = scr_pkg::FIELD_W;
   localparam int PW = scr_pkg::PROD_W;
   localparam int RW = scr_pkg::RAD_W;
   localparam int NW = scr_pkg::NUM_W;
   localparam int DW = scr_pkg::DEN_W;
   localparam int FB = scr_pkg::FRAC_BITS;

   logic                        en;
   // stage A
   logic                        a_vld_ff;
   logic [scr_pkg::CMD_W-1:0]   a_cmd_ff;
   logic [FW-1:0]               a_ma_ff, a_mb_ff, a_mc_ff, a_md_ff;
   logic                        a_na_ff, a_nb_ff, a_nc_ff;
   logic signed [FW:0]          a_sum_ff, a_dif_ff;
   // stage B
   logic                        b_vld_ff;
   logic [scr_pkg::CMD_W-1:0]   b_cmd_ff;
   logic [FW-1:0]               b_ma_ff, b_mb_ff, b_mc_ff;
   logic                        b_na_ff, b_nb_ff, b_nc_ff;
   logic signed [FW:0]          b_sum_ff, b_dif_ff;
   logic [PW-1:0]               p_ab_ff, p_aa_ff, p_bb_ff, p_cc_ff, p_dd_ff, p_ac_ff;

   logic signed [FW:0]          s_in;
   logic [RW-1:0]               bb, fourac, sq3, qsum;

   assign en        = !b_vld_ff || !job_full;
   assign in_ready  = en;
   assign job_valid = b_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         a_cmd_ff <= in_cmd;
         a_ma_ff  <= in_a[FW-1] ? FW'(~in_a + 1'b1) : in_a;
         a_mb_ff  <= in_b[FW-1] ? FW'(~in_b + 1'b1) : in_b;
         a_mc_ff  <= in_c[FW-1] ? FW'(~in_c + 1'b1) : in_c;
         a_md_ff  <= in_d[FW-1] ? FW'(~in_d + 1'b1) : in_d;
         a_na_ff  <= in_a[FW-1];
         a_nb_ff  <= in_b[FW-1];
         a_nc_ff  <= in_c[FW-1];
         a_sum_ff <= $signed({in_a[FW-1], in_a}) + $signed({in_b[FW-1], in_b});
         a_dif_ff <= $signed({in_a[FW-1], in_a}) - $signed({in_b[FW-1], in_b});

         b_cmd_ff <= a_cmd_ff;
         b_ma_ff  <= a_ma_ff;
         b_mb_ff  <= a_mb_ff;
         b_mc_ff  <= a_mc_ff;
         b_na_ff  <= a_na_ff;
         b_nb_ff  <= a_nb_ff;
         b_nc_ff  <= a_nc_ff;
         b_sum_ff <= a_sum_ff;
         b_dif_ff <= a_dif_ff;
         p_ab_ff  <= a_ma_ff * a_mb_ff;
         p_aa_ff  <= a_ma_ff * a_ma_ff;
         p_bb_ff  <= a_mb_ff * a_mb_ff;
         p_cc_ff  <= a_mc_ff * a_mc_ff;
         p_dd_ff  <= a_md_ff * a_md_ff;
         p_ac_ff  <= a_ma_ff * a_mc_ff;
      end
   end

   always_comb begin
      s_in   = (b_cmd_ff == scr_pkg::CMD_ADD) ? b_sum_ff : b_dif_ff;
      bb     = RW'(p_bb_ff);
      fourac = RW'(p_ac_ff) << 2;
      sq3    = RW'(p_aa_ff) + RW'(p_bb_ff) + RW'(p_cc_ff);
      qsum   = RW'(p_bb_ff) + RW'(p_cc_ff) + RW'(p_dd_ff);

      job.rad       = '0;
      job.num       = '0;
      job.den       = DW'(1);
      job.neg       = 1'b0;
      job.root_main = 1'b0;
      job.root_offs = 1'b0;
      job.code      = scr_pkg::ST_OK;

      case (b_cmd_ff)
         scr_pkg::CMD_ADD, scr_pkg::CMD_SUB: begin
            job.neg = s_in[FW];
            job.num = s_in[FW] ? NW'(-s_in) : NW'(s_in);
         end
         scr_pkg::CMD_MUL: begin
            job.neg = b_na_ff ^ b_nb_ff;
            job.num = NW'(p_ab_ff >> FB);
         end
         scr_pkg::CMD_DIV: begin
            if (b_mb_ff == '0) begin
               job.code = scr_pkg::ST_DIVZ;
            end else begin
               job.num = NW'(b_ma_ff) << FB;
               job.den = DW'(b_mb_ff);
               job.neg = b_na_ff ^ b_nb_ff;
            end
         end
         scr_pkg::CMD_LIN: begin
            if (b_ma_ff == '0) begin
               job.code = scr_pkg::ST_DIVZ;
            end else begin
               job.num = NW'(b_mb_ff) << FB;
               job.den = DW'(b_ma_ff);
               job.neg = !(b_na_ff ^ b_nb_ff);
            end
         end
         scr_pkg::CMD_QUAD: begin
            if (b_ma_ff == '0) begin
               // degenerate: fall back to the linear root -c/b
               if (b_mb_ff == '0) begin
                  job.code = scr_pkg::ST_DIVZ;
               end else begin
                  job.num = NW'(b_mc_ff) << FB;
                  job.den = DW'(b_mb_ff);
                  job.neg = !(b_nb_ff ^ b_nc_ff);
               end
            end else begin
               job.num       = NW'(b_mb_ff) << FB;
               job.den       = {b_ma_ff, 1'b0};
               job.neg       = !(b_na_ff ^ b_nb_ff);
               job.root_offs = 1'b1;
               job.code      = scr_pkg::ST_REAL;
               if ((b_na_ff != b_nc_ff) && (p_ac_ff != '0)) begin
                  job.rad = bb + fourac;
               end else if (bb >= fourac) begin
                  job.rad = bb - fourac;
               end else begin
                  job.rad  = fourac - bb;
                  job.code = scr_pkg::ST_CPLX;
               end
            end
         end
         scr_pkg::CMD_NRM3: begin
            job.rad       = sq3;
            job.root_main = 1'b1;
         end
         default: begin
            job.rad       = (RW'(p_aa_ff) >= qsum) ? RW'(p_aa_ff) - qsum
                                                   : qsum - RW'(p_aa_ff);
            job.root_main = 1'b1;
         end
      endcase
   end

endmodule

FILE: sv/scr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_queue: short job queue
// Decouple the front from the back so either side can stall on its own.
// ----------------------------------------------------------------------------
module scr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output scr_pkg::job_type head
);

   localparam int PW = scr_pkg::QPTR_W;

   scr_pkg::job_type mem_ff [scr_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      cnt_ff;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (PW+1)'(scr_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
      end
      if (do_push) mem_ff[wr_ff] <= push_job;
   end

endmodule

FILE: sv/scr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_back: square root, division and saturation pipeline
// One root bit per stage, then one bit of each of two quotients per stage,
// then clamp.
// ----------------------------------------------------------------------------
module scr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  scr_pkg::job_type             job,
   output logic                         job_pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [scr_pkg::FIELD_W-1:0]  out_main,
   output logic [scr_pkg::FIELD_W-1:0]  out_offs,
   output logic [scr_pkg::ST_W-1:0]     out_status
);

   localparam int FW = scr_pkg::FIELD_W;
   localparam int RW = scr_pkg::RAD_W;
   localparam int OW = scr_pkg::ROOT_W;
   localparam int MW = scr_pkg::REM_W;
   localparam int NW = scr_pkg::NUM_W;
   localparam int DW = scr_pkg::DEN_W;
   localparam int FB = scr_pkg::FRAC_BITS;

   typedef struct packed {
      logic                     valid;
      logic [RW-1:0]            rad;
      logic [MW-1:0]            rem;
      logic [OW-1:0]            root;
      logic [NW-1:0]            num;
      logic [DW-1:0]            den;
      logic                     neg;
      logic                     root_main;
      logic                     root_offs;
      logic [scr_pkg::ST_W-1:0] code;
   } sq_type;

   typedef struct packed {
      logic                     valid;
      logic [NW-1:0]            q0;
      logic [DW-1:0]            r0;
      logic [NW-1:0]            q1;
      logic [DW-1:0]            r1;
      logic [DW-1:0]            den;
      logic                     neg;
      logic [scr_pkg::ST_W-1:0] code;
   } dv_type;

   sq_type sq_ff [OW];
   sq_type sq_in [OW];
   dv_type dv_ff [NW];
   dv_type dv_in [NW];

   logic                     en;
   logic                     out_vld_ff;
   logic [FW-1:0]            main_ff, offs_ff;
   logic [scr_pkg::ST_W-1:0] st_ff;
   logic [FW:0]              sat_main, sat_offs;

   function automatic logic [FW:0] sat_fn(input logic neg, input logic [NW-1:0] mag);
      logic [NW-1:0] m;
      logic          clamp;
      begin
         m     = mag;
         clamp = 1'b0;
         if (!neg) begin
            if (mag > scr_pkg::SAT_LIM - NW'(1)) begin
               clamp = 1'b1;
               m     = scr_pkg::SAT_LIM - NW'(1);
            end
         end else begin
            if (mag > scr_pkg::SAT_LIM) begin
               clamp = 1'b1;
               m     = scr_pkg::SAT_LIM;
            end
            m = ~m + 1'b1;
         end
         if (mag == '0) begin
            m = '0;
         end
         return {clamp, m[FW-1:0]};
      end
   endfunction

   function automatic sq_type sq_step(input sq_type s);
      sq_type        r;
      logic [MW-1:0] rs, trial;
      begin
         r     = s;
         rs    = {s.rem[MW-3:0], s.rad[RW-1:RW-2]};
         trial = {s.root, 2'b01};
         r.rad = s.rad << 2;
         if (rs >= trial) begin
            r.rem  = rs - trial;
            r.root = {s.root[OW-2:0], 1'b1};
         end else begin
            r.rem  = rs;
            r.root = {s.root[OW-2:0], 1'b0};
         end
         return r;
      end
   endfunction

   function automatic dv_type dv_step(input dv_type s);
      dv_type      r;
      logic [DW:0] rs0, rs1;
      logic        g0, g1;
      begin
         r    = s;
         rs0  = {s.r0, s.q0[NW-1]};
         rs1  = {s.r1, s.q1[NW-1]};
         g0   = rs0 >= {1'b0, s.den};
         g1   = rs1 >= {1'b0, s.den};
         r.r0 = g0 ? DW'(rs0 - {1'b0, s.den}) : DW'(rs0);
         r.r1 = g1 ? DW'(rs1 - {1'b0, s.den}) : DW'(rs1);
         r.q0 = {s.q0[NW-2:0], g0};
         r.q1 = {s.q1[NW-2:0], g1};
         return r;
      end
   endfunction

   // advance the whole pipeline whenever the output slot frees up
   assign en      = !out_vld_ff || out_ready;
   assign job_pop = en;

   always_comb begin
      sq_type s0;
      sq_type sl;
      dv_type d0;
      s0.valid     = job_valid;
      s0.rad       = job.rad;
      s0.rem       = '0;
      s0.root      = '0;
      s0.num       = job.num;
      s0.den       = job.den;
      s0.neg       = job.neg;
      s0.root_main = job.root_main;
      s0.root_offs = job.root_offs;
      s0.code      = job.code;
      sq_in[0]     = sq_step(s0);
      for (int k = 1; k < OW; k++) begin
         sq_in[k] = sq_step(sq_ff[k-1]);
      end

      sl       = sq_ff[OW-1];
      d0.valid = sl.valid;
      d0.q0    = sl.root_main ? NW'(sl.root) : sl.num;
      d0.q1    = sl.root_offs ? (NW'(sl.root) << FB) : '0;
      d0.r0    = '0;
      d0.r1    = '0;
      d0.den   = sl.den;
      d0.neg   = sl.neg;
      d0.code  = sl.code;
      dv_in[0] = dv_step(d0);
      for (int k = 1; k < NW; k++) begin
         dv_in[k] = dv_step(dv_ff[k-1]);
      end

      sat_main = sat_fn(dv_ff[NW-1].neg, dv_ff[NW-1].q0);
      sat_offs = sat_fn(1'b0, dv_ff[NW-1].q1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < OW; k++) sq_ff[k].valid <= 1'b0;
         for (int k = 0; k < NW; k++) dv_ff[k].valid <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < OW; k++) sq_ff[k] <= sq_in[k];
         for (int k = 0; k < NW; k++) dv_ff[k] <= dv_in[k];
         out_vld_ff <= dv_ff[NW-1].valid;
      end
      if (en) begin
         main_ff <= sat_main[FW-1:0];
         offs_ff <= sat_offs[FW-1:0];
         st_ff   <= (sat_main[FW] || sat_offs[FW]) ? scr_pkg::ST_SAT : dv_ff[NW-1].code;
      end
   end

   assign out_valid  = out_vld_ff;
   assign out_main   = main_ff;
   assign out_offs   = offs_ff;
   assign out_status = st_ff;

endmodule

FILE: sv/scalar_calculator_with_roots_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_calculator_with_roots_top: Q16.16 calculator with quadratic solver
// Add, subtract, multiply, divide, linear and quadratic roots, vector norms.
// ----------------------------------------------------------------------------
// The block takes one command beat per cycle while its queue is not full,
// and returns one result beat per command, in order. A beat passes two
// front stages (the accepting edge loads the first), then the queue, 33
// square-root stages producing one root bit each, 49 divider stages
// producing one quotient bit each, and the output register. The throughput
// of one beat per cycle is set by the root and divider pipelines, which
// advance together whenever the output register is empty or is being taken.
// Results are truncated toward zero, square roots are floored, and any value
// outside the signed 32-bit range is clamped with status 4. Quadratic results
// carry the root centre in the main value and the non-negative offset;
// status 1 means real roots, 2 a complex pair.
module scalar_calculator_with_roots_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // opnd_a, opnd_b, opnd_c, opnd_d
   input  logic [2:0]    req_tuser,   // command
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,   // main_value, root_offset
   output logic [2:0]    rsp_tuser    // status
);

   localparam int FW = scr_pkg::FIELD_W;

   scr_pkg::job_type front_job, queue_head;
   logic             front_valid, queue_full, queue_empty, back_pop;
   logic [FW-1:0]    res_main, res_offs;

   // classify each beat and form its products
   scr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_a      (req_tdata[FW-1:0]),
      .in_b      (req_tdata[2*FW-1:FW]),
      .in_c      (req_tdata[3*FW-1:2*FW]),
      .in_d      (req_tdata[4*FW-1:3*FW]),
      .job_valid (front_valid),
      .job_full  (queue_full),
      .job       (front_job)
   );

   // hold jobs while the back end stalls
   scr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (back_pop),
      .empty    (queue_empty),
      .head     (queue_head)
   );

   // root, divide and clamp
   scr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (!queue_empty),
      .job        (queue_head),
      .job_pop    (back_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_main   (res_main),
      .out_offs   (res_offs),
      .out_status (rsp_tuser)
   );

   assign rsp_tdata = {res_offs, res_main};

endmodule

FILE: test/scalar_calculator_with_roots_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_calculator_with_roots_checker: result predictor and scoreboard
// Watches both stream channels, predicts each result from the command beat
// and compares every result beat in order, field by field.
// ----------------------------------------------------------------------------
module scalar_calculator_with_roots_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [127:0] req_tdata,   // opnd_a, opnd_b, opnd_c, opnd_d
   input  logic [2:0]   req_tuser,   // command
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,   // main_value, root_offset
   input  logic [2:0]   rsp_tuser,   // status
   output int           fail_count,
   output int           pending_count,
   output int           checked_count
);

   typedef struct packed {
      logic [31:0]              main_value;
      logic [31:0]              root_offset;
      logic [scr_pkg::ST_W-1:0] status;
   } calc_result_type;

   calc_result_type expected_results[$];

   function automatic logic [127:0] magnitude(longint x);
      return (x < 0) ? 128'(-x) : 128'(x);
   endfunction

   // floor square root; radicands here stay below 2^67
   function automatic logic [127:0] floor_sqrt(logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = 0;
      for (int i = 40; i >= 0; i--) begin
         t = r | (128'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic logic [31:0] clamp_q16(bit neg, logic [127:0] mag, ref bit clamped);
      logic [127:0] lim;
      lim = 128'd1 << 31;
      if (mag == 0) return 32'd0;
      if (!neg) begin
         if (mag > lim - 1) begin
            clamped = 1;
            mag = lim - 1;
         end
         return mag[31:0];
      end
      if (mag > lim) begin
         clamped = 1;
         mag = lim;
      end
      return 32'(-mag);
   endfunction

   function automatic calc_result_type compute_result(logic [2:0] cmd, logic [127:0] opnds);
      longint a, b, c, d;
      logic [127:0] ma, mb, mc, md, bb, fourac, disc, den, p, q;
      bit na, nb, nc, clamped, dneg;
      calc_result_type r;
      a = longint'($signed(opnds[31:0]));
      b = longint'($signed(opnds[63:32]));
      c = longint'($signed(opnds[95:64]));
      d = longint'($signed(opnds[127:96]));
      ma = magnitude(a);
      mb = magnitude(b);
      mc = magnitude(c);
      md = magnitude(d);
      na = a < 0;
      nb = b < 0;
      nc = c < 0;
      clamped = 0;
      dneg = 0;
      r = '0;
      r.status = scr_pkg::ST_OK;
      case (cmd)
         scr_pkg::CMD_ADD:
            r.main_value = clamp_q16(a + b < 0, magnitude(a + b), clamped);
         scr_pkg::CMD_SUB:
            r.main_value = clamp_q16(a - b < 0, magnitude(a - b), clamped);
         scr_pkg::CMD_MUL:
            r.main_value = clamp_q16(na != nb, (ma * mb) >> scr_pkg::FRAC_BITS, clamped);
         scr_pkg::CMD_DIV: begin
            if (mb == 0) r.status = scr_pkg::ST_DIVZ;
            else r.main_value = clamp_q16(na != nb, (ma << scr_pkg::FRAC_BITS) / mb,
                                          clamped);
         end
         scr_pkg::CMD_LIN: begin
            if (ma == 0) r.status = scr_pkg::ST_DIVZ;
            else r.main_value = clamp_q16(na == nb, (mb << scr_pkg::FRAC_BITS) / ma,
                                          clamped);
         end
         scr_pkg::CMD_QUAD: begin
            if (ma == 0) begin
               if (mb == 0) r.status = scr_pkg::ST_DIVZ;
               else r.main_value = clamp_q16(nb == nc, (mc << scr_pkg::FRAC_BITS) / mb,
                                             clamped);
            end else begin
               den = ma << 1;
               bb = mb * mb;
               fourac = (ma * mc) << 2;
               if (na != nc && fourac != 0) disc = bb + fourac;
               else if (bb >= fourac) disc = bb - fourac;
               else begin
                  disc = fourac - bb;
                  dneg = 1;
               end
               r.main_value = clamp_q16(na == nb, (mb << scr_pkg::FRAC_BITS) / den, clamped);
               r.root_offset = clamp_q16(0, (floor_sqrt(disc) << scr_pkg::FRAC_BITS) / den,
                                         clamped);
               r.status = dneg ? scr_pkg::ST_CPLX : scr_pkg::ST_REAL;
            end
         end
         scr_pkg::CMD_NRM3:
            r.main_value = clamp_q16(0, floor_sqrt(ma * ma + mb * mb + mc * mc), clamped);
         default: begin
            p = ma * ma;
            q = mb * mb + mc * mc + md * md;
            r.main_value = clamp_q16(0, floor_sqrt(p >= q ? p - q : q - p), clamped);
         end
      endcase
      if (clamped) r.status = scr_pkg::ST_SAT;
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      calc_result_type want, got;
      if (reset) begin
         fail_count <= 0;
         checked_count <= 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(compute_result(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.main_value = rsp_tdata[31:0];
            got.root_offset = rsp_tdata[63:32];
            got.status = rsp_tuser;
            checked_count <= checked_count + 1;
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("ERROR: result beat with nothing expected: %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want !== got) begin
                  if (fail_count < 10)
                     $display("ERROR: main %h/%h offset %h/%h status %0d/%0d (exp/act)",
                              want.main_value, got.main_value, want.root_offset,
                              got.root_offset, want.status, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: test/scalar_calculator_with_roots_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_calculator_with_roots_top_test: calculator regression
// Directed corner cases, then random command beats under three idling
// mixes, a long receiver hold-off and a drain pause; results are checked.
// ----------------------------------------------------------------------------
module scalar_calculator_with_roots_top_test;

   localparam int STALL_LIMIT = 3000;   // far above the pipeline latency plus hold-off
   localparam int HOLD_CYCLES = 300;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // opnd_a, opnd_b, opnd_c, opnd_d
   logic [2:0]   req_tuser;   // command
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // main_value, root_offset
   logic [2:0]   rsp_tuser;   // status

   int fail_count, pending_count, checked_count;
   int tx_idle_pct, rx_idle_pct;
   int sent_count;
   int hold_left;
   bit hold_request;
   int stall_cycles;

   scalar_calculator_with_roots_top DUT (.*);

   scalar_calculator_with_roots_checker checker_i (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Receiver: random back-pressure, or a long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
         hold_left = 0;
      end else begin
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", stall_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offer one command beat and hold it until it is accepted.
   task automatic send_cmd(logic [2:0] cmd, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {d, c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   // Operand mix: extremes, small Q16.16 values, raw noise.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
         4, 5: return 32'($signed($urandom_range(2 ** 20)) - 2 ** 19);
         6, 7: return 32'($signed($urandom_range(2 ** 26)) - 2 ** 25);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_cmd(3'($urandom_range(7)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
   endtask

   initial begin
      clock = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = scr_pkg::CMD_ADD;
      hold_request = 0;
      tx_idle_pct = 14;
      rx_idle_pct = 64;
      sent_count = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed corners: saturation, zero divisors, root cases, negative zero
      send_cmd(scr_pkg::CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
      send_cmd(scr_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_cmd(scr_pkg::CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
      send_cmd(scr_pkg::CMD_SUB, 32'h0001_0000, 32'h0001_0000, 0, 0);
      send_cmd(scr_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_cmd(scr_pkg::CMD_MUL, 32'hffff_ffff, 32'h0000_0001, 0, 0);
      send_cmd(scr_pkg::CMD_MUL, 32'h0003_0000, 32'hfffe_0000, 0, 0);
      send_cmd(scr_pkg::CMD_DIV, 32'h0005_0000, 32'h0, 0, 0);
      send_cmd(scr_pkg::CMD_DIV, 32'h8000_0000, 32'h0000_0001, 0, 0);
      send_cmd(scr_pkg::CMD_DIV, 32'hfff9_0000, 32'h0002_0000, 0, 0);
      send_cmd(scr_pkg::CMD_LIN, 32'h0, 32'h0001_0000, 0, 0);
      send_cmd(scr_pkg::CMD_LIN, 32'h0002_0000, 32'hfffa_0000, 0, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'h0, 32'h0, 32'h0001_0000, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'h0, 32'h0002_0000, 32'h0006_0000, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'h0001_0000, 32'hfffd_0000, 32'h0002_0000, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'h0001_0000, 32'h0001_0000, 32'h0005_0000, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'hffff_0000, 32'h0004_0000, 32'h0002_0000, 0);
      send_cmd(scr_pkg::CMD_QUAD, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 0);
      send_cmd(scr_pkg::CMD_NRM3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
      send_cmd(scr_pkg::CMD_NRM3, 32'h0003_0000, 32'hfffc_0000, 32'h0, 0);
      send_cmd(scr_pkg::CMD_MINK, 32'h0005_0000, 32'h0003_0000, 32'h0004_0000, 32'h0);
      send_cmd(scr_pkg::CMD_MINK, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_cmd(scr_pkg::CMD_MINK, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0001_0000);

      // phase one: slow receiver, with a long hold-off while beats keep coming
      send_random(300);
      hold_request = 1;
      send_random(400);

      // phase two: slow sender; drain fully before going on
      tx_idle_pct = 64;
      rx_idle_pct = 14;
      send_random(300);
      req_tvalid <= 0;
      wait (pending_count == 0);
      @(posedge clock);
      send_random(350);

      // phase three: full rate both ways
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random(650);
      req_tvalid <= 0;

      wait (pending_count == 0);
      repeat (100) @(posedge clock);
      $display("Covered %0d command beats (all eight commands, corners, random operands)",
               sent_count);
      $display("Checked %0d result beats under three back-pressure mixes", checked_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
